// ===== sv/pcf_pkg.sv =====
// ----------------------------------------------------------------------------
// pcf_pkg: shared constants for the pose frame transform
// CORDIC phase format, gain constant, guard bits and the arctangent table.
// ----------------------------------------------------------------------------
package pcf_pkg;

    // phase word: 2^32 equals one full turn
    localparam int PHASE_W = 32;

    // extra fraction bits carried through the CORDIC datapath
    localparam int GUARD = 20;

    // CORDIC gain compensation, 0x26DD3B6A / 2^30
    localparam int GAIN_SHIFT = 30;
    localparam logic signed [31:0] KGAIN = 32'sd652032874;

    // stage count the table supports
    localparam int ATAN_ENTRIES = 24;

    typedef logic [PHASE_W-1:0] t_phase;
    typedef t_phase t_atan_tab [ATAN_ENTRIES];

    // atan(2^-i) in phase units, rounded to nearest
    localparam t_atan_tab ATAN_PHASE = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

// ===== sv/pcf_if.sv =====
// ----------------------------------------------------------------------------
// pcf_if: request and result channels of the pose frame transform
// Valid/ready handshake; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface pcf_req_if #(
    parameter int COORD_WIDTH = 24,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic        [ANGLE_WIDTH-1:0] point_heading;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic        [ANGLE_WIDTH-1:0] origin_heading;

    modport source (
        output valid, point_x, point_y, point_heading,
               origin_x, origin_y, origin_heading,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_heading,
               origin_x, origin_y, origin_heading,
        output ready
    );
endinterface

interface pcf_res_if #(
    parameter int COORD_WIDTH = 24,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic        [ANGLE_WIDTH-1:0] out_heading;

    modport source (
        output valid, out_x, out_y, out_heading,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_heading,
        output ready
    );
endinterface

// ===== sv/pcf_front.sv =====
// ----------------------------------------------------------------------------
// pcf_front: frame selection, quarter-turn pre-rotation and gain scaling
// Two register stages: offset/pre-rotate, then multiply by the CORDIC gain.
// ----------------------------------------------------------------------------
module pcf_front #(
    parameter int COORD_WIDTH = 24,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic                            i_dir,
    input  logic signed [COORD_WIDTH-1:0]   i_px,
    input  logic signed [COORD_WIDTH-1:0]   i_py,
    input  logic signed [COORD_WIDTH-1:0]   i_ox,
    input  logic signed [COORD_WIDTH-1:0]   i_oy,
    input  logic        [ANGLE_WIDTH-1:0]   i_oh,
    output logic signed [COORD_WIDTH+22:0]  o_a,
    output logic signed [COORD_WIDTH+22:0]  o_b,
    output logic signed [pcf_pkg::PHASE_W-1:0] o_z
);
    localparam int VW = COORD_WIDTH + 1;
    localparam int PW = VW + 32;
    localparam int DW = VW + pcf_pkg::GUARD + 2;
    localparam int SHIFT = pcf_pkg::GAIN_SHIFT - pcf_pkg::GUARD;
    localparam int ZW = pcf_pkg::PHASE_W;

    // quadrant codes of the rotation angle
    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    logic signed [VW-1:0]          vx, vy, va, vb;
    logic        [ANGLE_WIDTH-1:0] ang;
    logic signed [VW-1:0]          r_a, r_b, n_a, n_b;
    logic signed [ZW-1:0]          r_z, n_z;
    logic signed [PW-1:0]          prod_a, prod_b;
    logic signed [DW-1:0]          r_ga, r_gb;
    logic signed [ZW-1:0]          r_gz;

    // world to robot: subtract origin, rotate by -heading; else by heading
    always_comb begin
        if (i_dir) begin
            vx  = VW'(i_px);
            vy  = VW'(i_py);
            ang = i_oh;
        end else begin
            vx  = VW'(i_px) - VW'(i_ox);
            vy  = VW'(i_py) - VW'(i_oy);
            ang = '0 - i_oh;
        end
    end

    // exact quarter-turn pre-rotation from the top two angle bits
    always_comb begin
        case (ang[ANGLE_WIDTH-1 -: 2])
            QUAD_90: begin
                va = -vy;
                vb = vx;
            end
            QUAD_180: begin
                va = -vx;
                vb = -vy;
            end
            QUAD_270: begin
                va = vy;
                vb = -vx;
            end
            QUAD_0: begin
                va = vx;
                vb = vy;
            end
            default: begin
                va = vx;
                vb = vy;
            end
        endcase
        n_a = va;
        n_b = vb;
        // residual phase in [0, 90 deg)
        n_z = {2'b00, ang[ANGLE_WIDTH-3:0], {(ZW - ANGLE_WIDTH){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_z <= n_z;
        end
    end

    // gain compensation, floor shift to GUARD fraction bits
    assign prod_a = PW'(r_a) * PW'(pcf_pkg::KGAIN);
    assign prod_b = PW'(r_b) * PW'(pcf_pkg::KGAIN);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ga <= prod_a[SHIFT +: DW];
            r_gb <= prod_b[SHIFT +: DW];
            r_gz <= r_z;
        end
    end

    assign o_a = r_ga;
    assign o_b = r_gb;
    assign o_z = r_gz;

endmodule

// ===== sv/pcf_cell.sv =====
// ----------------------------------------------------------------------------
// pcf_cell: one CORDIC micro-rotation stage
// Holds one rotated vector and residual phase; hands them to the next cell.
// ----------------------------------------------------------------------------
module pcf_cell #(
    parameter int DW    = 47,
    parameter int STAGE = 0
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [DW-1:0]               i_a,
    input  logic signed [DW-1:0]               i_b,
    input  logic signed [pcf_pkg::PHASE_W-1:0] i_z,
    output logic signed [DW-1:0]               o_a,
    output logic signed [DW-1:0]               o_b,
    output logic signed [pcf_pkg::PHASE_W-1:0] o_z
);
    localparam int ZW = pcf_pkg::PHASE_W;
    localparam logic signed [ZW-1:0] ATAN = pcf_pkg::ATAN_PHASE[STAGE];

    logic signed [DW-1:0] da, db;
    logic signed [DW-1:0] r_a, r_b, n_a, n_b;
    logic signed [ZW-1:0] r_z, n_z;

    // arithmetic shifts round toward minus infinity
    assign da = i_b >>> STAGE;
    assign db = i_a >>> STAGE;

    // rotate toward zero residual phase
    always_comb begin
        if (!i_z[ZW-1]) begin
            n_a = i_a - da;
            n_b = i_b + db;
            n_z = i_z - ATAN;
        end else begin
            n_a = i_a + da;
            n_b = i_b - db;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_z <= n_z;
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_z = r_z;

endmodule

// ===== sv/pcf_back.sv =====
// ----------------------------------------------------------------------------
// pcf_back: rounding to coordinate LSB, origin add and saturation
// One register stage for rounding; origin add and clamp follow it.
// ----------------------------------------------------------------------------
module pcf_back #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [COORD_WIDTH+22:0] i_a,
    input  logic signed [COORD_WIDTH+22:0] i_b,
    input  logic                           i_dir,
    input  logic signed [COORD_WIDTH-1:0]  i_ox,
    input  logic signed [COORD_WIDTH-1:0]  i_oy,
    output logic signed [COORD_WIDTH-1:0]  o_x,
    output logic signed [COORD_WIDTH-1:0]  o_y
);
    localparam int DW = COORD_WIDTH + 23;
    localparam int RW = DW - pcf_pkg::GUARD;
    localparam int SW = RW + 1;
    localparam logic signed [DW-1:0] HALF = DW'(1) << (pcf_pkg::GUARD - 1);

    logic signed [DW-1:0]          rnd_a, rnd_b;
    logic signed [RW-1:0]          r_rx, r_ry;
    logic signed [SW-1:0]          add_x, add_y, sum_x, sum_y;

    // round half up, then floor shift
    assign rnd_a = i_a + HALF;
    assign rnd_b = i_b + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx <= rnd_a[DW-1:pcf_pkg::GUARD];
            r_ry <= rnd_b[DW-1:pcf_pkg::GUARD];
        end
    end

    // origin add in robot-to-world mode
    assign add_x = i_dir ? SW'(i_ox) : '0;
    assign add_y = i_dir ? SW'(i_oy) : '0;
    assign sum_x = SW'(r_rx) + add_x;
    assign sum_y = SW'(r_ry) + add_y;

    // clamp: in range when all bits above the result sign agree
    function automatic logic [COORD_WIDTH-1:0] sat(input logic [SW-1:0] v);
        logic [SW-COORD_WIDTH:0] top;
        top = v[SW-1:COORD_WIDTH-1];
        if (top == '0 || top == '1) begin
            sat = v[COORD_WIDTH-1:0];
        end else if (v[SW-1]) begin
            sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    assign o_x = sat(sum_x);
    assign o_y = sat(sum_y);

endmodule

// ===== sv/pose_frame_transform.sv =====
// ----------------------------------------------------------------------------
// pose_frame_transform: 2D rigid change of frame through a CORDIC cell chain
// Throughput: one request per cycle; the chain of CORDIC cells advances
// together and stalls only when both the result register and skid are full.
// Reset: synchronous active-low, clears pipeline valids, result/skid valids
// and sets direction to world-to-robot.
// ----------------------------------------------------------------------------
module pose_frame_transform #(
    parameter int COORD_WIDTH   = 24,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_dir_we,
    input  logic          i_dir_wdata,
    pcf_req_if.sink       i_req,
    pcf_res_if.source     o_res
);
    localparam int DW    = COORD_WIDTH + 23;
    localparam int ZW    = pcf_pkg::PHASE_W;
    localparam int DEPTH = CORDIC_STAGES + 3;
    localparam int LAST  = DEPTH - 1;
    localparam int SDW   = 1 + ANGLE_WIDTH + 2 * COORD_WIDTH;

    // side data carried alongside the datapath
    typedef logic [SDW-1:0] t_side;

    logic                          r_direction;
    logic                          adv, accept, out_free;
    logic [DEPTH-1:0]              r_vld;
    t_side                         r_side [DEPTH];
    t_side                         n_side;

    logic signed [DW-1:0]          c_a [CORDIC_STAGES+1];
    logic signed [DW-1:0]          c_b [CORDIC_STAGES+1];
    logic signed [ZW-1:0]          c_z [CORDIC_STAGES+1];

    logic                          end_dir;
    logic        [ANGLE_WIDTH-1:0] end_hd;
    logic signed [COORD_WIDTH-1:0] end_ox, end_oy, end_x, end_y;

    logic                          r_out_vld, r_skid_vld;
    logic signed [COORD_WIDTH-1:0] r_out_x, r_out_y, r_skid_x, r_skid_y;
    logic        [ANGLE_WIDTH-1:0] r_out_hd, r_skid_hd;

    // direction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_dir_we) begin
            r_direction <= i_dir_wdata;
        end
    end

    // pipeline moves while the skid is free
    assign adv         = !r_skid_vld;
    assign i_req.ready = adv;
    assign accept      = i_req.valid && adv;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], accept};
        end
    end

    // side data line: direction, heading, origin
    assign n_side = {r_direction, i_req.point_heading, i_req.origin_x, i_req.origin_y};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            for (int k = 1; k < DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign {end_dir, end_hd, end_ox, end_oy} = r_side[LAST];

    // front end: offset, pre-rotation, gain
    pcf_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_front (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_dir (r_direction),
        .i_px  (i_req.point_x),
        .i_py  (i_req.point_y),
        .i_ox  (i_req.origin_x),
        .i_oy  (i_req.origin_y),
        .i_oh  (i_req.origin_heading),
        .o_a   (c_a[0]),
        .o_b   (c_b[0]),
        .o_z   (c_z[0])
    );

    // chain of CORDIC cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        pcf_cell #(
            .DW    (DW),
            .STAGE (g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_a   (c_a[g]),
            .i_b   (c_b[g]),
            .i_z   (c_z[g]),
            .o_a   (c_a[g+1]),
            .o_b   (c_b[g+1]),
            .o_z   (c_z[g+1])
        );
    end

    // back end: round, origin add, clamp
    pcf_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (c_a[CORDIC_STAGES]),
        .i_b   (c_b[CORDIC_STAGES]),
        .i_dir (end_dir),
        .i_ox  (end_ox),
        .i_oy  (end_oy),
        .o_x   (end_x),
        .o_y   (end_y)
    );

    // result register with skid
    assign out_free = !r_out_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= r_vld[LAST];
            end
        end else if (r_vld[LAST]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_vld) begin
                r_out_x  <= r_skid_x;
                r_out_y  <= r_skid_y;
                r_out_hd <= r_skid_hd;
            end else begin
                r_out_x  <= end_x;
                r_out_y  <= end_y;
                r_out_hd <= end_hd;
            end
        end else if (adv) begin
            r_skid_x  <= end_x;
            r_skid_y  <= end_y;
            r_skid_hd <= end_hd;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.out_x       = r_out_x;
    assign o_res.out_y       = r_out_y;
    assign o_res.out_heading = r_out_hd;

    // skid only ever holds a result behind a waiting one
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a result while result register is empty");

    // a result leaving the chain into a blocked output lands in the skid
    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready && r_vld[LAST] && !r_skid_vld) |=> r_skid_vld)
        else $error("result lost at blocked output");

    // an accepted request enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_vld[0])
        else $error("accepted request did not enter the pipeline");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pose_frame_transform
// Drives pose requests through the valid/ready request channel, predicts each
// transformed pose with a bit-accurate CORDIC model kept in the bench, and
// compares every result in order. Covers both frame directions, quarter-turn
// and near-boundary headings, saturation, random idling on both channels, a
// long result hold-off and sender pauses.
// ----------------------------------------------------------------------------
module tb;

    localparam int CW          = 24;
    localparam int AW          = 16;
    localparam int STAGES      = 16;
    localparam int LATENCY     = STAGES + 4;
    localparam int DRAIN_LIMIT = 20000;
    localparam longint COORD_MAX  = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN  = -COORD_MAX - 1;
    localparam longint ROUND_HALF = longint'(1) << (pcf_pkg::GUARD - 1);
    localparam logic signed [CW-1:0] SAT_HI = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] SAT_LO = {1'b1, {(CW-1){1'b0}}};
    localparam longint ONE_M = 4096;

    // quadrant codes of the rotation angle
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    typedef enum bit {
        DIR_W2R = 1'b0,
        DIR_R2W = 1'b1
    } t_frame_dir;

    typedef struct {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic        [AW-1:0] ph;
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic        [AW-1:0] oh;
    } t_pose_req;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic        [AW-1:0] heading;
    } t_pose_res;

    logic i_clk;
    logic i_rst_n;
    logic i_dir_we;
    logic i_dir_wdata;

    pcf_req_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) req_if ();
    pcf_res_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) res_if ();

    pose_frame_transform #(
        .COORD_WIDTH   (CW),
        .ANGLE_WIDTH   (AW),
        .CORDIC_STAGES (STAGES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dir_we    (i_dir_we),
        .i_dir_wdata (i_dir_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // bench copy of the direction register and the in-order result store
    t_frame_dir dir_model = DIR_W2R;
    t_pose_res  pending_poses[$];

    int n_errors      = 0;
    int n_sent        = 0;
    int n_w2r         = 0;
    int n_r2w         = 0;
    int n_checked     = 0;
    int n_saturated   = 0;
    int tx_max_gap    = 0;
    int rx_max_stall  = 0;
    int rx_stall_left = 0;
    int rx_hold_left  = 0;

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // --------------------------------------------------------------------
    // Prediction
    // --------------------------------------------------------------------

    // rotate (vx, vy) by a binary angle; result in coordinate LSBs
    function automatic void rotate_vec(input longint vx, input longint vy,
                                       input logic [AW-1:0] ang,
                                       output longint rx, output longint ry);
        logic [pcf_pkg::PHASE_W-1:0] phase;
        longint a, b, z, t, da, db, step;
        phase = {ang, {(pcf_pkg::PHASE_W-AW){1'b0}}};
        // exact quarter-turn pre-rotation from the top two phase bits
        case (phase[pcf_pkg::PHASE_W-1 -: 2])
            QUAD_90: begin a = -vy; b = vx;  end
            QUAD_180: begin a = -vx; b = -vy; end
            QUAD_270: begin a = vy;  b = -vx; end
            default: begin a = vx; b = vy; end
        endcase
        // gain compensation into the guard-bit format, floor shifts
        a = (a * longint'(pcf_pkg::KGAIN)) >>> (pcf_pkg::GAIN_SHIFT - pcf_pkg::GUARD);
        b = (b * longint'(pcf_pkg::KGAIN)) >>> (pcf_pkg::GAIN_SHIFT - pcf_pkg::GUARD);
        z = phase[pcf_pkg::PHASE_W-3:0];
        for (int i = 0; i < STAGES && i < pcf_pkg::ATAN_ENTRIES; i++) begin
            da   = b >>> i;
            db   = a >>> i;
            step = pcf_pkg::ATAN_PHASE[i];
            if (z >= 0) begin
                t = a - da;
                b = b + db;
                z = z - step;
            end else begin
                t = a + da;
                b = b - db;
                z = z + step;
            end
            a = t;
        end
        // round half up back to the coordinate LSB
        rx = (a + ROUND_HALF) >>> pcf_pkg::GUARD;
        ry = (b + ROUND_HALF) >>> pcf_pkg::GUARD;
    endfunction

    function automatic logic signed [CW-1:0] saturate_coord(input longint v);
        if (v > COORD_MAX) begin
            return SAT_HI;
        end
        if (v < COORD_MIN) begin
            return SAT_LO;
        end
        return v[CW-1:0];
    endfunction

    function automatic t_pose_res transform_pose(input t_pose_req r, input t_frame_dir d);
        longint rx, ry;
        logic [AW-1:0] neg_heading;
        t_pose_res res;
        if (d == DIR_W2R) begin
            // subtract origin, then rotate by minus origin heading
            neg_heading = -r.oh;
            rotate_vec(longint'(r.px) - longint'(r.ox), longint'(r.py) - longint'(r.oy),
                       neg_heading, rx, ry);
        end else begin
            // rotate by origin heading, then add origin
            rotate_vec(longint'(r.px), longint'(r.py), r.oh, rx, ry);
            rx = rx + longint'(r.ox);
            ry = ry + longint'(r.oy);
        end
        res.x       = saturate_coord(rx);
        res.y       = saturate_coord(ry);
        res.heading = r.ph;
        return res;
    endfunction

    // --------------------------------------------------------------------
    // Checking
    // --------------------------------------------------------------------

    task automatic report_error(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        n_errors++;
    endtask

    // compare each accepted result with the oldest pending prediction
    always @(posedge i_clk) begin : check_result
        t_pose_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            rx_stall_left = $urandom_range(0, rx_max_stall);
            if (pending_poses.size() == 0) begin
                report_error($sformatf("unexpected result x=%0d y=%0d heading=%0d",
                                       res_if.out_x, res_if.out_y, res_if.out_heading));
            end else begin
                want = pending_poses.pop_front();
                n_checked++;
                if (want.x == SAT_HI || want.x == SAT_LO ||
                    want.y == SAT_HI || want.y == SAT_LO) begin
                    n_saturated++;
                end
                if (res_if.out_x !== want.x) begin
                    report_error($sformatf("result %0d out_x got %0d want %0d",
                                           n_checked, res_if.out_x, want.x));
                end
                if (res_if.out_y !== want.y) begin
                    report_error($sformatf("result %0d out_y got %0d want %0d",
                                           n_checked, res_if.out_y, want.y));
                end
                if (res_if.out_heading !== want.heading) begin
                    report_error($sformatf("result %0d out_heading got %0d want %0d",
                                           n_checked, res_if.out_heading, want.heading));
                end
            end
        end
    end

    // result side: long hold-off first, then the per-result stall
    initial begin : result_sink
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                res_if.ready <= 1'b0;
                rx_hold_left--;
            end else if (rx_stall_left > 0) begin
                res_if.ready <= 1'b0;
                rx_stall_left--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // --------------------------------------------------------------------
    // Stimulus helpers
    // --------------------------------------------------------------------

    // send one request after a random gap; predict it on acceptance
    task automatic send_pose(input t_pose_req r);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.point_x        <= r.px;
        req_if.point_y        <= r.py;
        req_if.point_heading  <= r.ph;
        req_if.origin_x       <= r.ox;
        req_if.origin_y       <= r.oy;
        req_if.origin_heading <= r.oh;
        req_if.valid          <= 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_poses.push_back(transform_pose(r, dir_model));
        n_sent++;
        if (dir_model == DIR_W2R) begin
            n_w2r++;
        end else begin
            n_r2w++;
        end
    endtask

    // stop sending and wait for every pending result, plus pipeline slack
    task automatic settle_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_poses.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_direction(input t_frame_dir d);
        settle_results();
        @(negedge i_clk);
        i_dir_we    <= 1'b1;
        i_dir_wdata <= d;
        @(negedge i_clk);
        i_dir_we    <= 1'b0;
        dir_model = d;
    endtask

    task automatic set_idling(input int tx_gap, input int rx_stall);
        tx_max_gap   = tx_gap;
        rx_max_stall = rx_stall;
    endtask

    function automatic t_pose_req make_pose(input longint px, input longint py, input int ph,
                                            input longint ox, input longint oy, input int oh);
        t_pose_req r;
        r.px = px[CW-1:0];
        r.py = py[CW-1:0];
        r.ph = ph[AW-1:0];
        r.ox = ox[CW-1:0];
        r.oy = oy[CW-1:0];
        r.oh = oh[AW-1:0];
        return r;
    endfunction

    // wide draws hit every bit; narrow ones keep most results unsaturated
    function automatic logic signed [CW-1:0] random_coord(input bit wide);
        if (wide) begin
            return CW'($urandom);
        end
        return CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endfunction

    // a quarter of headings sit just around a quadrant boundary
    function automatic logic [AW-1:0] random_angle();
        if ($urandom_range(0, 3) == 0) begin
            return AW'(($urandom_range(0, 3) << (AW - 2)) + $urandom_range(0, 8) - 4);
        end
        return AW'($urandom);
    endfunction

    function automatic t_pose_req random_pose();
        t_pose_req r;
        bit wide;
        wide = ($urandom_range(0, 3) == 0);
        r.px = random_coord(wide);
        r.py = random_coord(wide);
        r.ph = AW'($urandom);
        r.ox = random_coord(wide);
        r.oy = random_coord(wide);
        r.oh = random_angle();
        return r;
    endfunction

    // --------------------------------------------------------------------
    // Tests
    // --------------------------------------------------------------------

    // direction left at its reset value: world to robot
    task automatic test_world_to_robot_directed();
        set_idling(0, 0);
        send_pose(make_pose(0, 0, 0, 0, 0, 0));
        send_pose(make_pose(ONE_M, 0, 0, 0, 0, 'h0000));
        send_pose(make_pose(ONE_M, 0, 'h4000, 0, 0, 'h4000));
        send_pose(make_pose(ONE_M, 2 * ONE_M, 'h8000, 0, 0, 'h8000));
        send_pose(make_pose(ONE_M, 2 * ONE_M, 'hFFFF, 0, 0, 'hC000));
        send_pose(make_pose(3 * ONE_M, -ONE_M, 'h1234, ONE_M, ONE_M, 'h0001));
        send_pose(make_pose(3 * ONE_M, -ONE_M, 0, ONE_M, ONE_M, 'hFFFF));
        send_pose(make_pose(-1, -1, 'h5555, 0, 0, 'h3FFF));
        // difference overflows the coordinate range both ways
        send_pose(make_pose(COORD_MAX, COORD_MAX, 'hAAAA, COORD_MIN, COORD_MIN, 0));
        send_pose(make_pose(COORD_MIN, COORD_MIN, 0, COORD_MAX, COORD_MAX, 0));
        // rotation alone pushes past the range
        send_pose(make_pose(COORD_MAX, COORD_MAX, 0, 0, 0, 'h2000));
        send_pose(make_pose(COORD_MIN, COORD_MAX, 'hFFFF, 0, 0, 'h8000));
    endtask

    task automatic test_robot_to_world_directed();
        write_direction(DIR_R2W);
        send_pose(make_pose(0, 0, 0, COORD_MAX, COORD_MIN, 'h7FFF));
        send_pose(make_pose(ONE_M, 0, 0, 2 * ONE_M, -ONE_M, 'h4000));
        send_pose(make_pose(ONE_M, ONE_M, 'hFFFF, -3 * ONE_M, 0, 'hC000));
        send_pose(make_pose(-ONE_M, ONE_M, 'h0001, ONE_M, -ONE_M, 'h0001));
        // sum with the origin saturates; then half turns near the range edge
        send_pose(make_pose(COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0));
        send_pose(make_pose(COORD_MIN, COORD_MIN, 0, COORD_MIN, COORD_MIN, 0));
        send_pose(make_pose(COORD_MIN, 0, 0, 0, 0, 'h8000));
        send_pose(make_pose(COORD_MIN, COORD_MIN, 'h8000, COORD_MIN, COORD_MIN, 'h8000));
    endtask

    // random poses in blocks with changing direction and idle mix
    task automatic test_random_mix();
        for (int blk = 0; blk < 11; blk++) begin
            case (blk % 5)
                0: set_idling(0, 0);
                1: set_idling(19, 19);
                2: set_idling(0, 19);
                3: set_idling(19, 0);
                default: set_idling(3, 3);
            endcase
            if (blk < 2) begin
                write_direction(blk == 0 ? DIR_W2R : DIR_R2W);
            end else if (blk % 3 == 0) begin
                write_direction(t_frame_dir'($urandom_range(0, 1)));
            end else if (blk % 4 == 2) begin
                // sender pauses until the pipeline is empty
                settle_results();
            end
            for (int k = 0; k < 42; k++) begin
                send_pose(random_pose());
            end
        end
    endtask

    // results held off long enough for the block to stall its request side
    task automatic test_result_backpressure();
        settle_results();
        set_idling(0, 0);
        rx_hold_left = 300;
        for (int k = 0; k < 60; k++) begin
            send_pose(random_pose());
        end
        settle_results();
    endtask

    // --------------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------------
    initial begin
        i_rst_n               = 1'b0;
        i_dir_we              = 1'b0;
        i_dir_wdata           = 1'b0;
        req_if.valid          = 1'b0;
        req_if.point_x        = '0;
        req_if.point_y        = '0;
        req_if.point_heading  = '0;
        req_if.origin_x       = '0;
        req_if.origin_y       = '0;
        req_if.origin_heading = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_world_to_robot_directed();
        test_robot_to_world_directed();
        test_random_mix();
        test_result_backpressure();

        settle_results();
        if (pending_poses.size() != 0) begin
            report_error($sformatf("%0d results never arrived", pending_poses.size()));
        end
        $display("Covered %0d requests: %0d world-to-robot, %0d robot-to-world.",
                 n_sent, n_w2r, n_r2w);
        $display("Checked %0d results, %0d saturated, under idle mixes and a long hold-off.",
                 n_checked, n_saturated);
        if (n_errors == 0) begin
            $display("[pose_frame_transform] OK");
        end else begin
            $display("[pose_frame_transform] ERROR");
        end
        $finish;
    end

    // run-time limit
    initial begin : watchdog
        #3_000_000;
        $display("[pose_frame_transform] ERROR");
        $finish;
    end

endmodule
